// ===== hw/rtl/ifc_pkg.sv =====
// Shared types and constants for the intercept fire control block.
package ifc_pkg;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CSUM,
        ST_CCHK,
        ST_ASUM,
        ST_ACHK,
        ST_BSUM,
        ST_BCHK,
        ST_DISC,
        ST_DCHK,
        ST_SQRT_T,
        ST_ROOT,
        ST_DIV_T,
        ST_PRED,
        ST_NORM,
        ST_ESUM,
        ST_LEN,
        ST_SQRT_L,
        ST_DSTART,
        ST_DIV_D,
        ST_DSTORE,
        ST_FIN
    } state_t;

    // Left shift applied to a multiplier product before accumulation.
    typedef enum logic [1:0] {
        SH_0,
        SH_24,
        SH_48
    } mac_shift_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MISSILE_SPEED     = 2'd0;
    localparam logic [1:0] CFG_SHOOTING_DISTANCE = 2'd1;
    localparam logic [1:0] CFG_FIRE_COOLDOWN     = 2'd2;

    // Datapath widths.
    localparam int CHUNK_W  = 24;
    localparam int ACC_W    = 90;
    localparam int DISC_W   = 86;
    localparam int ROOT_W   = 43;
    localparam int REM_W    = 46;
    localparam int DIV_W    = 60;
    localparam int TQ_W     = 24;
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd43;
    localparam logic [CNT_W-1:0] TDIV_STEPS = 6'd24;
    localparam logic [CNT_W-1:0] DDIV_STEPS = 6'd16;

    localparam logic [15:0] DIR_NEG_FULL = 16'h8000;
    localparam logic [15:0] DIR_MAX      = 16'h7FFF;

endpackage

// ===== hw/rtl/intercept_fire_control.sv =====
// Intercept fire control: lead-angle targeting with a shared multiply-accumulate unit.
//
// Each transaction on the s_ channel is one tick and yields exactly one transaction on
// the m_ channel. When a target is present, the cooldown has run out and the target is
// inside the shooting distance, the block solves the intercept quadratic, takes the
// smallest non-negative root as the intercept time (Q16 seconds, saturating at 24 bits)
// and reports the unit aim direction in Q1.15; otherwise fire, direction and time are
// all zero. The block takes one tick at a time: s_ready is high only while the
// sequencer is idle, and a finished result may still wait on m_ready while the next
// tick is taken. A tick that is rejected early (no target, cooldown, out of range)
// goes straight to the result. A full solution uses one 24 x 24 bit multiplier with
// a 90 bit accumulator that forms every product in turn, a two-bits-per-cycle square
// root unit that runs twice and a one-bit-per-cycle divider that runs for the
// intercept time and once per direction component. Configuration registers are
// written through cfg_wr_en, cfg_index and cfg_wdata and should only be changed
// while the block is idle.
module intercept_fire_control #(
    parameter int POS_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write port.
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_wdata,
    // Tick input channel.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [15:0]                s_delta_time,
    input  logic                       s_target_present,
    input  logic signed [POS_BITS-1:0] s_target_x,
    input  logic signed [POS_BITS-1:0] s_target_y,
    input  logic signed [POS_BITS-1:0] s_target_z,
    input  logic signed [17:0]         s_target_vx,
    input  logic signed [17:0]         s_target_vy,
    input  logic signed [17:0]         s_target_vz,
    input  logic signed [POS_BITS-1:0] s_launcher_x,
    input  logic signed [POS_BITS-1:0] s_launcher_y,
    input  logic signed [POS_BITS-1:0] s_launcher_z,
    // Result channel.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_fire,
    output logic signed [15:0]         m_dir_x,
    output logic signed [15:0]         m_dir_y,
    output logic signed [15:0]         m_dir_z,
    output logic [23:0]                m_intercept_time
);

    // Width used for the range test; wide enough for both the offset magnitude and the
    // 23 bit shooting distance.
    localparam int RW = (POS_BITS + 1 > 23) ? POS_BITS + 1 : 23;

    localparam int AW = ifc_pkg::ACC_W;

    // Configuration and persistent state.
    logic [16:0] speed_reg;
    logic [22:0] range_reg;
    logic [31:0] cool_reg;
    logic [31:0] since_reg, since_next;

    // Sequencer.
    ifc_pkg::state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] idx_reg, idx_next;
    logic [ifc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // Captured tick.
    logic [15:0] dt_reg, dt_next;
    logic        present_reg, present_next;
    logic signed [POS_BITS:0] d_reg [3];
    logic signed [POS_BITS:0] d_next [3];
    logic [17:0] vmag_reg [3];
    logic [17:0] vmag_next [3];
    logic [2:0]  vneg_reg, vneg_next;

    // Intermediate quantities of the solution.
    logic [22:0] dmag_reg [3];
    logic [22:0] dmag_next [3];
    logic [2:0]  dneg_reg, dneg_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [45:0] c_reg, c_next;
    logic [35:0] a_reg, a_next;
    logic        aneg_reg, aneg_next;
    logic [41:0] bmag_reg, bmag_next;
    logic        bneg_reg, bneg_next;
    logic [ifc_pkg::TQ_W-1:0] tq_reg, tq_next;
    logic [41:0] e_reg [3];
    logic [41:0] e_next [3];
    logic [2:0]  pneg_reg, pneg_next;
    logic [30:0] len_reg, len_next;
    logic [15:0] dir_reg [3];
    logic [15:0] dir_next [3];
    logic        fire_reg, fire_next;

    // Square root unit.
    logic [ifc_pkg::DISC_W-1:0] sq_x_reg, sq_x_next;
    logic [ifc_pkg::REM_W-1:0]  sq_rem_reg, sq_rem_next;
    logic [ifc_pkg::ROOT_W-1:0] sq_root_reg, sq_root_next;

    // Divider.
    logic [ifc_pkg::DIV_W-1:0] dv_rem_reg, dv_rem_next;
    logic [ifc_pkg::DIV_W-1:0] dv_div_reg, dv_div_next;
    logic [ifc_pkg::TQ_W-1:0]  dv_q_reg, dv_q_next;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic        m_fire_reg, m_fire_next;
    logic [15:0] m_dir_reg [3];
    logic [15:0] m_dir_next [3];
    logic [23:0] m_time_reg, m_time_next;

    // Shared multiply-accumulate unit.
    logic [ifc_pkg::CHUNK_W-1:0] mul_a, mul_b;
    logic                        mul_en, mul_clr, mul_neg;
    ifc_pkg::mac_shift_t         mul_sh;
    logic [2*ifc_pkg::CHUNK_W-1:0] mul_prod;
    logic [AW-1:0]               mul_term, mac_acc, acc_mag;

    // Helper nets.
    logic [RW-1:0] dm_ext [3];
    logic [2:0]    dm_neg;
    logic          range_ok;
    logic [ifc_pkg::REM_W-1:0] sq_rem2, sq_trial;
    logic                      sq_ge;
    logic                      dv_ge;
    logic signed [44:0] nbn, root_lo, root_hi;
    logic [43:0]        n_sel;
    logic [32:0]        since_sum;
    logic [15:0]        q_clamp;

    assign s_ready          = (state_reg == ifc_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_fire           = m_fire_reg;
    assign m_dir_x          = m_dir_reg[0];
    assign m_dir_y          = m_dir_reg[1];
    assign m_dir_z          = m_dir_reg[2];
    assign m_intercept_time = m_time_reg;

    // Magnitudes of the captured offsets and the range test against each axis.
    always_comb begin
        range_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            dm_neg[i] = d_reg[i][POS_BITS];
            dm_ext[i] = RW'(dm_neg[i] ? unsigned'(-d_reg[i]) : unsigned'(d_reg[i]));
            if (dm_ext[i] >= RW'(range_reg)) begin
                range_ok = 1'b0;
            end
        end
    end

    // The multiplier product is shifted by a whole number of chunks and added to, or
    // subtracted from, the accumulator.
    always_comb begin
        mul_prod = mul_a * mul_b;
        case (mul_sh)
            ifc_pkg::SH_0:  mul_term = AW'(mul_prod);
            ifc_pkg::SH_24: mul_term = AW'(mul_prod) << ifc_pkg::CHUNK_W;
            ifc_pkg::SH_48: mul_term = AW'(mul_prod) << (2 * ifc_pkg::CHUNK_W);
            default:        mul_term = AW'(mul_prod);
        endcase
        mac_acc = (mul_clr ? '0 : acc_reg) + (mul_neg ? (~mul_term + 1'b1) : mul_term);
    end

    assign acc_next = mul_en ? mac_acc : acc_reg;
    assign acc_mag  = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;

    // One square root digit per cycle: two radicand bits enter, one root bit leaves.
    assign sq_rem2  = {sq_rem_reg[ifc_pkg::REM_W-3:0], sq_x_reg[ifc_pkg::DISC_W-1 -: 2]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);

    // Restoring division, one quotient bit per cycle.
    assign dv_ge = (dv_rem_reg >= dv_div_reg);

    // Candidate roots: -b' minus and plus the square root of the discriminant.
    assign nbn     = (bneg_reg ^ aneg_reg) ? signed'({3'b000, bmag_reg})
                                           : -signed'({3'b000, bmag_reg});
    assign root_lo = nbn - signed'({2'b00, sq_root_reg});
    assign root_hi = nbn + signed'({2'b00, sq_root_reg});
    assign n_sel   = !root_lo[44] ? root_lo[43:0] : root_hi[43:0];

    // A firing tick restarts the since-fired time before the elapsed time is added.
    assign since_sum = {1'b0, (fire_reg ? 32'd0 : since_reg)} + 33'(dt_reg);

    assign q_clamp = dv_q_reg[15] ? ifc_pkg::DIR_MAX : dv_q_reg[15:0];

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        since_next   = since_reg;
        dt_next      = dt_reg;
        present_next = present_reg;
        d_next       = d_reg;
        vmag_next    = vmag_reg;
        vneg_next    = vneg_reg;
        dmag_next    = dmag_reg;
        dneg_next    = dneg_reg;
        c_next       = c_reg;
        a_next       = a_reg;
        aneg_next    = aneg_reg;
        bmag_next    = bmag_reg;
        bneg_next    = bneg_reg;
        tq_next      = tq_reg;
        e_next       = e_reg;
        pneg_next    = pneg_reg;
        len_next     = len_reg;
        dir_next     = dir_reg;
        fire_next    = fire_reg;
        sq_x_next    = sq_x_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        dv_rem_next  = dv_rem_reg;
        dv_div_next  = dv_div_reg;
        dv_q_next    = dv_q_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_fire_next  = m_fire_reg;
        m_dir_next   = m_dir_reg;
        m_time_next  = m_time_reg;
        mul_en       = 1'b0;
        mul_clr      = 1'b0;
        mul_neg      = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        mul_sh       = ifc_pkg::SH_0;

        case (state_reg)
            ifc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    dt_next      = s_delta_time;
                    present_next = s_target_present;
                    d_next[0]    = {s_target_x[POS_BITS-1], s_target_x}
                                 - {s_launcher_x[POS_BITS-1], s_launcher_x};
                    d_next[1]    = {s_target_y[POS_BITS-1], s_target_y}
                                 - {s_launcher_y[POS_BITS-1], s_launcher_y};
                    d_next[2]    = {s_target_z[POS_BITS-1], s_target_z}
                                 - {s_launcher_z[POS_BITS-1], s_launcher_z};
                    vneg_next    = {s_target_vz[17], s_target_vy[17], s_target_vx[17]};
                    vmag_next[0] = s_target_vx[17] ? unsigned'(-s_target_vx) : s_target_vx;
                    vmag_next[1] = s_target_vy[17] ? unsigned'(-s_target_vy) : s_target_vy;
                    vmag_next[2] = s_target_vz[17] ? unsigned'(-s_target_vz) : s_target_vz;
                    state_next   = ifc_pkg::ST_CHECK;
                end
            end

            ifc_pkg::ST_CHECK: begin
                for (int i = 0; i < 3; i++) begin
                    dmag_next[i] = dm_ext[i][22:0];
                end
                dneg_next = dm_neg;
                step_next = '0;
                idx_next  = '0;
                fire_next = 1'b0;
                if (present_reg && (since_reg > cool_reg) && range_ok) begin
                    state_next = ifc_pkg::ST_CSUM;
                end else begin
                    state_next = ifc_pkg::ST_FIN;
                end
            end

            ifc_pkg::ST_CSUM: begin
                mul_en = 1'b1;
                if (step_reg != 3'd3) begin
                    mul_a     = ifc_pkg::CHUNK_W'(dmag_reg[step_reg[1:0]]);
                    mul_b     = ifc_pkg::CHUNK_W'(dmag_reg[step_reg[1:0]]);
                    mul_clr   = (step_reg == 3'd0);
                    step_next = step_reg + 3'd1;
                end else begin
                    c_next     = acc_reg[45:0];
                    mul_a      = ifc_pkg::CHUNK_W'(range_reg);
                    mul_b      = ifc_pkg::CHUNK_W'(range_reg);
                    mul_neg    = 1'b1;
                    step_next  = '0;
                    state_next = ifc_pkg::ST_CCHK;
                end
            end

            ifc_pkg::ST_CCHK: begin
                // Distance squared minus range squared must be negative.
                state_next = acc_reg[AW-1] ? ifc_pkg::ST_ASUM : ifc_pkg::ST_FIN;
            end

            ifc_pkg::ST_ASUM: begin
                mul_en = 1'b1;
                if (step_reg != 3'd3) begin
                    mul_a     = ifc_pkg::CHUNK_W'(vmag_reg[step_reg[1:0]]);
                    mul_b     = ifc_pkg::CHUNK_W'(vmag_reg[step_reg[1:0]]);
                    mul_clr   = (step_reg == 3'd0);
                    step_next = step_reg + 3'd1;
                end else begin
                    mul_a      = ifc_pkg::CHUNK_W'(speed_reg);
                    mul_b      = ifc_pkg::CHUNK_W'(speed_reg);
                    mul_neg    = 1'b1;
                    step_next  = '0;
                    state_next = ifc_pkg::ST_ACHK;
                end
            end

            ifc_pkg::ST_ACHK: begin
                a_next    = acc_mag[35:0];
                aneg_next = acc_reg[AW-1];
                state_next = (acc_reg == '0) ? ifc_pkg::ST_FIN : ifc_pkg::ST_BSUM;
            end

            ifc_pkg::ST_BSUM: begin
                mul_en  = 1'b1;
                mul_a   = ifc_pkg::CHUNK_W'(dmag_reg[step_reg[1:0]]);
                mul_b   = ifc_pkg::CHUNK_W'(vmag_reg[step_reg[1:0]]);
                mul_neg = dneg_reg[step_reg[1:0]] ^ vneg_reg[step_reg[1:0]];
                mul_clr = (step_reg == 3'd0);
                if (step_reg == 3'd2) begin
                    step_next  = '0;
                    state_next = ifc_pkg::ST_BCHK;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end

            ifc_pkg::ST_BCHK: begin
                bmag_next  = acc_mag[41:0];
                bneg_next  = acc_reg[AW-1];
                step_next  = '0;
                state_next = ifc_pkg::ST_DISC;
            end

            ifc_pkg::ST_DISC: begin
                // b squared, then plus or minus a times c, chunk by chunk.
                mul_en    = 1'b1;
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        mul_a   = bmag_reg[23:0];
                        mul_b   = bmag_reg[23:0];
                        mul_clr = 1'b1;
                    end
                    3'd1, 3'd2: begin
                        mul_a  = bmag_reg[23:0];
                        mul_b  = {6'd0, bmag_reg[41:24]};
                        mul_sh = ifc_pkg::SH_24;
                    end
                    3'd3: begin
                        mul_a  = {6'd0, bmag_reg[41:24]};
                        mul_b  = {6'd0, bmag_reg[41:24]};
                        mul_sh = ifc_pkg::SH_48;
                    end
                    3'd4: begin
                        mul_a   = a_reg[23:0];
                        mul_b   = c_reg[23:0];
                        mul_neg = ~aneg_reg;
                    end
                    3'd5: begin
                        mul_a   = a_reg[23:0];
                        mul_b   = {2'd0, c_reg[45:24]};
                        mul_neg = ~aneg_reg;
                        mul_sh  = ifc_pkg::SH_24;
                    end
                    3'd6: begin
                        mul_a   = {12'd0, a_reg[35:24]};
                        mul_b   = c_reg[23:0];
                        mul_neg = ~aneg_reg;
                        mul_sh  = ifc_pkg::SH_24;
                    end
                    default: begin
                        mul_a      = {12'd0, a_reg[35:24]};
                        mul_b      = {2'd0, c_reg[45:24]};
                        mul_neg    = ~aneg_reg;
                        mul_sh     = ifc_pkg::SH_48;
                        step_next  = '0;
                        state_next = ifc_pkg::ST_DCHK;
                    end
                endcase
            end

            ifc_pkg::ST_DCHK: begin
                sq_x_next    = acc_reg[ifc_pkg::DISC_W-1:0];
                sq_rem_next  = '0;
                sq_root_next = '0;
                cnt_next     = ifc_pkg::SQRT_STEPS;
                if (acc_reg[AW-1] || (acc_reg == '0)) begin
                    state_next = ifc_pkg::ST_FIN;
                end else begin
                    state_next = ifc_pkg::ST_SQRT_T;
                end
            end

            ifc_pkg::ST_SQRT_T, ifc_pkg::ST_SQRT_L: begin
                sq_rem_next  = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
                sq_root_next = {sq_root_reg[ifc_pkg::ROOT_W-2:0], sq_ge};
                sq_x_next    = {sq_x_reg[ifc_pkg::DISC_W-3:0], 2'b00};
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == 6'd1) begin
                    if (state_reg == ifc_pkg::ST_SQRT_T) begin
                        state_next = ifc_pkg::ST_ROOT;
                    end else begin
                        len_next   = {sq_root_reg[29:0], sq_ge};
                        idx_next   = '0;
                        state_next = ifc_pkg::ST_DSTART;
                    end
                end
            end

            ifc_pkg::ST_ROOT: begin
                step_next   = '0;
                idx_next    = '0;
                dv_rem_next = {n_sel, 16'd0};
                dv_div_next = ifc_pkg::DIV_W'({a_reg, 23'd0});
                dv_q_next   = '0;
                cnt_next    = ifc_pkg::TDIV_STEPS;
                if (root_lo[44] && root_hi[44]) begin
                    state_next = ifc_pkg::ST_FIN;
                end else if (n_sel >= {a_reg, 8'd0}) begin
                    // Intercept time beyond the 24 bit range.
                    tq_next    = '1;
                    state_next = ifc_pkg::ST_PRED;
                end else begin
                    state_next = ifc_pkg::ST_DIV_T;
                end
            end

            ifc_pkg::ST_DIV_T, ifc_pkg::ST_DIV_D: begin
                dv_rem_next = dv_ge ? (dv_rem_reg - dv_div_reg) : dv_rem_reg;
                dv_div_next = dv_div_reg >> 1;
                dv_q_next   = {dv_q_reg[ifc_pkg::TQ_W-2:0], dv_ge};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == 6'd1) begin
                    if (state_reg == ifc_pkg::ST_DIV_T) begin
                        tq_next    = {dv_q_reg[ifc_pkg::TQ_W-2:0], dv_ge};
                        state_next = ifc_pkg::ST_PRED;
                    end else begin
                        state_next = ifc_pkg::ST_DSTORE;
                    end
                end
            end

            ifc_pkg::ST_PRED: begin
                // Predicted offset: d * 65536 + v * t for each axis in turn.
                case (step_reg)
                    3'd0: begin
                        mul_en    = 1'b1;
                        mul_clr   = 1'b1;
                        mul_a     = ifc_pkg::CHUNK_W'(dmag_reg[idx_reg]);
                        mul_b     = 24'd65536;
                        mul_neg   = dneg_reg[idx_reg];
                        step_next = 3'd1;
                    end
                    3'd1: begin
                        mul_en    = 1'b1;
                        mul_a     = ifc_pkg::CHUNK_W'(vmag_reg[idx_reg]);
                        mul_b     = tq_reg;
                        mul_neg   = vneg_reg[idx_reg];
                        step_next = 3'd2;
                    end
                    default: begin
                        e_next[idx_reg]    = acc_mag[41:0];
                        pneg_next[idx_reg] = acc_reg[AW-1];
                        step_next          = '0;
                        if (idx_reg == 2'd2) begin
                            idx_next   = '0;
                            state_next = ifc_pkg::ST_NORM;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                endcase
            end

            ifc_pkg::ST_NORM: begin
                // Halve all three until every component is below 2^30.
                if ((e_reg[0][41:30] != '0) || (e_reg[1][41:30] != '0) ||
                    (e_reg[2][41:30] != '0)) begin
                    for (int i = 0; i < 3; i++) begin
                        e_next[i] = e_reg[i] >> 1;
                    end
                end else begin
                    step_next  = '0;
                    idx_next   = '0;
                    state_next = ifc_pkg::ST_ESUM;
                end
            end

            ifc_pkg::ST_ESUM: begin
                mul_en    = 1'b1;
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        mul_a   = e_reg[idx_reg][23:0];
                        mul_b   = e_reg[idx_reg][23:0];
                        mul_clr = (idx_reg == 2'd0);
                    end
                    3'd1, 3'd2: begin
                        mul_a  = e_reg[idx_reg][23:0];
                        mul_b  = {18'd0, e_reg[idx_reg][29:24]};
                        mul_sh = ifc_pkg::SH_24;
                    end
                    default: begin
                        mul_a     = {18'd0, e_reg[idx_reg][29:24]};
                        mul_b     = {18'd0, e_reg[idx_reg][29:24]};
                        mul_sh    = ifc_pkg::SH_48;
                        step_next = '0;
                        if (idx_reg == 2'd2) begin
                            idx_next   = '0;
                            state_next = ifc_pkg::ST_LEN;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                endcase
            end

            ifc_pkg::ST_LEN: begin
                sq_x_next    = acc_reg[ifc_pkg::DISC_W-1:0];
                sq_rem_next  = '0;
                sq_root_next = '0;
                cnt_next     = ifc_pkg::SQRT_STEPS;
                state_next   = ifc_pkg::ST_SQRT_L;
            end

            ifc_pkg::ST_DSTART: begin
                // Rounded quotient: (e * 32768 + len / 2) / len.
                dv_rem_next = ifc_pkg::DIV_W'({e_reg[idx_reg][29:0], 15'd0})
                            + ifc_pkg::DIV_W'(len_reg >> 1);
                dv_div_next = ifc_pkg::DIV_W'({len_reg, 15'd0});
                dv_q_next   = '0;
                cnt_next    = ifc_pkg::DDIV_STEPS;
                if (len_reg == '0) begin
                    state_next = ifc_pkg::ST_DSTORE;
                end else begin
                    state_next = ifc_pkg::ST_DIV_D;
                end
            end

            ifc_pkg::ST_DSTORE: begin
                dir_next[idx_reg] = pneg_reg[idx_reg] ? (~q_clamp + 1'b1) : q_clamp;
                if (idx_reg == 2'd2) begin
                    idx_next   = '0;
                    fire_next  = 1'b1;
                    state_next = ifc_pkg::ST_FIN;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ifc_pkg::ST_DSTART;
                end
            end

            ifc_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_fire_next  = fire_reg;
                    for (int i = 0; i < 3; i++) begin
                        m_dir_next[i] = fire_reg ? dir_reg[i] : 16'd0;
                    end
                    m_time_next = fire_reg ? tq_reg : 24'd0;
                    since_next  = since_sum[32] ? 32'hFFFF_FFFF : since_sum[31:0];
                    state_next  = ifc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ifc_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and the rest of the control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ifc_pkg::ST_IDLE;
            step_reg    <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            since_reg   <= '0;
            fire_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            since_reg   <= since_next;
            fire_reg    <= fire_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration registers; an index beyond the three registers is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= 17'd100000;
            range_reg <= 23'd500000;
            cool_reg  <= 32'd2000000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ifc_pkg::CFG_MISSILE_SPEED:     speed_reg <= cfg_wdata[16:0];
                ifc_pkg::CFG_SHOOTING_DISTANCE: range_reg <= cfg_wdata[22:0];
                ifc_pkg::CFG_FIRE_COOLDOWN:     cool_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        dt_reg      <= dt_next;
        present_reg <= present_next;
        d_reg       <= d_next;
        vmag_reg    <= vmag_next;
        vneg_reg    <= vneg_next;
        dmag_reg    <= dmag_next;
        dneg_reg    <= dneg_next;
        acc_reg     <= acc_next;
        c_reg       <= c_next;
        a_reg       <= a_next;
        aneg_reg    <= aneg_next;
        bmag_reg    <= bmag_next;
        bneg_reg    <= bneg_next;
        tq_reg      <= tq_next;
        e_reg       <= e_next;
        pneg_reg    <= pneg_next;
        len_reg     <= len_next;
        dir_reg     <= dir_next;
        sq_x_reg    <= sq_x_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_rem_reg  <= dv_rem_next;
        dv_div_reg  <= dv_div_next;
        dv_q_reg    <= dv_q_next;
        m_fire_reg  <= m_fire_next;
        m_dir_reg   <= m_dir_next;
        m_time_reg  <= m_time_next;
    end

endmodule

// ===== hw/rtl/ifc_checker.sv =====
// Port-level checker for the intercept fire control block and its binding.
module ifc_checker #(
    parameter int POS_BITS = 24
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_wr_en,
    input logic [1:0]                 cfg_index,
    input logic [31:0]                cfg_wdata,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [15:0]                s_delta_time,
    input logic                       s_target_present,
    input logic signed [POS_BITS-1:0] s_target_x,
    input logic signed [POS_BITS-1:0] s_target_y,
    input logic signed [POS_BITS-1:0] s_target_z,
    input logic signed [17:0]         s_target_vx,
    input logic signed [17:0]         s_target_vy,
    input logic signed [17:0]         s_target_vz,
    input logic signed [POS_BITS-1:0] s_launcher_x,
    input logic signed [POS_BITS-1:0] s_launcher_y,
    input logic signed [POS_BITS-1:0] s_launcher_z,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_fire,
    input logic signed [15:0]         m_dir_x,
    input logic signed [15:0]         m_dir_y,
    input logic signed [15:0]         m_dir_z,
    input logic [23:0]                m_intercept_time
);

    // A result without a shot carries no direction and no time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fire |-> (m_dir_x == '0) && (m_dir_y == '0) && (m_dir_z == '0)
                               && (m_intercept_time == '0))
        else $error("non-firing result carries a direction or time");

    // Direction components are clamped to plus or minus full scale less one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fire |-> (m_dir_x != ifc_pkg::DIR_NEG_FULL)
                              && (m_dir_y != ifc_pkg::DIR_NEG_FULL)
                              && (m_dir_z != ifc_pkg::DIR_NEG_FULL))
        else $error("direction component at negative full scale");

    // The block works on one tick at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second tick taken while the first is in progress");

    // A stalled result transaction holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fire) && $stable(m_dir_x)
                                && $stable(m_dir_y) && $stable(m_dir_z)
                                && $stable(m_intercept_time))
        else $error("stalled result changed");

endmodule

bind intercept_fire_control ifc_checker #(.POS_BITS(POS_BITS)) u_ifc_checker (.*);
